// ===== src/bit_vector_store_core_macros.svh =====
// Assertion macros shared by the bit vector store RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BIT_VECTOR_STORE_CORE_MACROS_SVH
`define BIT_VECTOR_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BVS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bit_vector_store_core: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bit_vector_store_core: assertion failed");

`endif

// ===== src/bvs_pkg.sv =====
// Package for the bit vector store: widths, constants, action and status codes,
// state encoding and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package bvs_pkg;

  localparam int unsigned WordsDefault = 16;
  localparam int unsigned WordBits     = 64;
  localparam int unsigned IdxW         = 10;
  localparam int unsigned CountW       = 11;
  localparam int unsigned CfgW         = 5;
  localparam int unsigned InTdataW     = 16;
  localparam int unsigned OutTdataW    = 56;

  localparam logic [CfgW-1:0] WordsInUseReset = 5'd16;

  localparam logic [WordBits-1:0] HashStart = 64'd1234;
  localparam logic [WordBits-1:0] HashMult  = 64'hffffffffffffffc5;
  // The multiplier is 2^64 - 59, so a product modulo 2^64 is the negated product by 59.
  localparam logic [5:0] HashNegMult = 6'(64'd0 - HashMult);

  typedef enum logic [2:0] {
    ACT_SET       = 3'd0,
    ACT_CLEAR     = 3'd1,
    ACT_TEST      = 3'd2,
    ACT_CLEAR_ALL = 3'd3,
    ACT_COUNT     = 3'd4,
    ACT_LOWEST    = 3'd5,
    ACT_HASH      = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODIFY,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic            clr;
    logic            vld;
    logic [CfgW-1:0] idx;
  } walk_ctl_t;

  typedef struct packed {
    logic                busy;
    logic [CountW-1:0]   count;
    logic                found;
    logic [IdxW-1:0]     first;
    logic [WordBits-1:0] hash;
  } walk_acc_t;

  typedef struct packed {
    logic              is_member;
    logic [CountW-1:0] bit_count;
    logic [IdxW-1:0]   first_set;
    logic [31:0]       hash_value;
    status_e           status;
  } result_t;

endpackage

// ===== src/bvs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module bvs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bvs_word_unit.sv =====
// Shared per-word unit: takes one stored word per cycle and accumulates the
// bit count, the lowest set bit and the running hash. Depends on bvs_pkg.
`timescale 1ns / 1ps

module bvs_word_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bvs_pkg::walk_ctl_t       ctl_i,
  input  logic [bvs_pkg::WordBits-1:0] rdata_i,
  output bvs_pkg::walk_acc_t       acc_o
);

  import bvs_pkg::*;

  // Stage 1 tags the word coming back from the RAM read.
  logic            rd_vld_q;
  logic [CfgW-1:0] rd_idx_q;

  logic [6:0]          pop;
  logic [5:0]          low;
  logic [5:0]          idx_inc;
  logic [WordBits-1:0] prod;

  // Stage 2 holds the per-word figures.
  logic                s2_vld_q;
  logic                s2_nz_q;
  logic [6:0]          s2_pop_q;
  logic [5:0]          s2_low_q;
  logic [CfgW-1:0]     s2_idx_q;
  logic [WordBits-1:0] s2_prod_q;

  logic [CountW-1:0]   count_q, count_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     first_q, first_d;
  logic [WordBits-1:0] hash_q, hash_d;
  logic [WordBits-1:0] mixed;
  logic [WordBits-1:0] scaled;

  always_comb begin
    low = '0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      if (rdata_i[b]) begin
        low = 6'(b);
      end
    end
  end

  assign pop     = 7'($countones(rdata_i));
  assign idx_inc = {1'b0, rd_idx_q} + 6'd1;
  assign prod    = rdata_i * {58'd0, idx_inc};

  assign mixed  = hash_q ^ s2_prod_q;
  assign scaled = mixed * {58'd0, HashNegMult};

  always_comb begin
    count_d = count_q;
    found_d = found_q;
    first_d = first_q;
    hash_d  = hash_q;
    if (ctl_i.clr) begin
      count_d = '0;
      found_d = 1'b0;
      first_d = '0;
      hash_d  = HashStart;
    end else if (s2_vld_q) begin
      count_d = count_q + {4'd0, s2_pop_q};
      // Only the first sixteen words can ever hold a set bit.
      if (s2_nz_q && !found_q) begin
        found_d = 1'b1;
        first_d = {s2_idx_q[3:0], s2_low_q};
      end
      if (s2_nz_q) begin
        hash_d = 64'd0 - scaled;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      count_q  <= '0;
      found_q  <= 1'b0;
      first_q  <= '0;
      hash_q   <= HashStart;
    end else begin
      rd_vld_q <= ctl_i.vld;
      s2_vld_q <= rd_vld_q;
      count_q  <= count_d;
      found_q  <= found_d;
      first_q  <= first_d;
      hash_q   <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= ctl_i.idx;
    s2_nz_q   <= |rdata_i;
    s2_pop_q  <= pop;
    s2_low_q  <= low;
    s2_idx_q  <= rd_idx_q;
    s2_prod_q <= prod;
  end

  assign acc_o.busy  = rd_vld_q | s2_vld_q;
  assign acc_o.count = count_q;
  assign acc_o.found = found_q;
  assign acc_o.first = first_q;
  assign acc_o.hash  = hash_q;

endmodule

// ===== src/bit_vector_store_core.sv =====
// Bit vector store: a set of up to 1024 bit positions kept as 64-bit words in a
// RAM with one write and one read port, with set, clear, test, clear all, bit count,
// lowest set bit and a folded 32-bit hash over the words in use; one result per
// input transaction. The block takes one transaction at a time. Set, clear and test
// read one word, and set and clear write it back modified; an index out of range
// goes straight to the result with a range status. Count, lowest set and hash stream
// the words in use (the register value capped at WORDS) through one shared word
// unit at one word per cycle, then wait until the word unit has settled after the
// last word; with no word in use nothing is streamed. Clear all sweeps the RAM one
// word per cycle. After reset a clearing pass over all WORDS words runs before the
// first input is accepted; register writes are taken at any time. A result waiting
// at the output holds the block in its finish state until it is taken.
// Depends on bvs_pkg, bvs_ram, bvs_word_unit and bit_vector_store_core_macros.svh.
`timescale 1ns / 1ps
`include "bit_vector_store_core_macros.svh"

module bit_vector_store_core #(
  parameter int unsigned WORDS = bvs_pkg::WordsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bvs_pkg::CfgW-1:0]      cfg_wdata_i,    // words_in_use
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bvs_pkg::InTdataW-1:0]  s_axis_tdata,   // action[2:0], bit_index[12:3]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // is_member[0], bit_count[11:1], first_set[21:12], hash_value[53:22], status[55:54]
  output logic [bvs_pkg::OutTdataW-1:0] m_axis_tdata
);

  import bvs_pkg::*;

  localparam int unsigned AddrW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned NwCap = (WORDS < 31) ? WORDS : 31;

  state_e          state_q, state_d;
  logic [CfgW-1:0] words_q;
  logic [CfgW-1:0] nw;
  action_e         op_q, op_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CfgW-1:0] walk_idx_q, walk_idx_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic            clr_report_q, clr_report_d;
  result_t         res_q, res_d;
  result_t         m_res_q, m_res_d;
  logic            m_valid_q, m_valid_d;

  action_e         in_action;
  logic [IdxW-1:0] in_idx;
  logic            in_range;
  logic            s_fire;
  logic            out_free;

  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [WordBits-1:0] ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  logic [WordBits-1:0] ram_rdata;
  logic [WordBits-1:0] bit_mask;

  walk_ctl_t walk_ctl;
  walk_acc_t walk_acc;

  assign nw        = (words_q > 5'(NwCap)) ? 5'(NwCap) : words_q;
  assign in_action = action_e'(s_axis_tdata[2:0]);
  assign in_idx    = s_axis_tdata[12:3];
  assign in_range  = {1'b0, in_idx[9:6]} < nw;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign bit_mask  = 64'd1 << idx_q[5:0];

  bvs_ram #(
    .Width (WordBits),
    .Depth (WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bvs_word_unit u_word_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (walk_ctl),
    .rdata_i (ram_rdata),
    .acc_o   (walk_acc)
  );

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    idx_d        = idx_q;
    walk_idx_d   = walk_idx_q;
    clr_cnt_d    = clr_cnt_q;
    clr_report_d = clr_report_q;
    res_d        = res_q;
    m_res_d      = m_res_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    walk_ctl     = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        if (clr_cnt_q == AddrW'(WORDS - 1)) begin
          clr_cnt_d    = '0;
          clr_report_d = 1'b0;
          res_d        = '0;
          state_d      = clr_report_q ? ST_FINISH : ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AddrW'(1);
        end
      end

      ST_IDLE: begin
        ram_raddr = AddrW'(in_idx[9:6]);
        if (s_fire) begin
          op_d  = in_action;
          idx_d = in_idx;
          res_d = '0;
          case (in_action) inside
            ACT_SET, ACT_CLEAR, ACT_TEST: begin
              if (in_range) begin
                state_d = ST_MODIFY;
              end else begin
                res_d.status = STAT_RANGE;
                state_d      = ST_FINISH;
              end
            end
            ACT_CLEAR_ALL: begin
              clr_report_d = 1'b1;
              state_d      = ST_CLEAR;
            end
            ACT_COUNT, ACT_LOWEST, ACT_HASH: begin
              walk_ctl.clr = 1'b1;
              walk_idx_d   = '0;
              state_d      = (nw == '0) ? ST_DRAIN : ST_WALK;
            end
            default: begin
              state_d = ST_FINISH;
            end
          endcase
        end
      end

      ST_MODIFY: begin
        ram_waddr = AddrW'(idx_q[9:6]);
        unique case (op_q)
          ACT_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_mask;
          end
          ACT_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_mask;
          end
          default: begin
            res_d.is_member = |(ram_rdata & bit_mask);
          end
        endcase
        state_d = ST_FINISH;
      end

      ST_WALK: begin
        walk_ctl.vld = 1'b1;
        walk_ctl.idx = walk_idx_q;
        ram_raddr    = AddrW'(walk_idx_q);
        if (walk_idx_q == nw - 5'd1) begin
          state_d = ST_DRAIN;
        end else begin
          walk_idx_d = walk_idx_q + 5'd1;
        end
      end

      ST_DRAIN: begin
        if (!walk_acc.busy) begin
          unique case (op_q)
            ACT_COUNT: begin
              res_d.bit_count = walk_acc.count;
            end
            ACT_LOWEST: begin
              if (walk_acc.found) begin
                res_d.first_set = walk_acc.first;
              end else begin
                res_d.status = STAT_EMPTY;
              end
            end
            default: begin
              res_d.hash_value = walk_acc.hash[31:0] ^ walk_acc.hash[63:32];
            end
          endcase
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          m_res_d   = res_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      words_q      <= WordsInUseReset;
      walk_idx_q   <= '0;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_idx_q   <= walk_idx_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_report_q <= clr_report_d;
      m_valid_q    <= m_valid_d;
      if (cfg_we_i) begin
        words_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    res_q   <= res_d;
    m_res_q <= m_res_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_res_q.status, m_res_q.hash_value, m_res_q.first_set,
                          m_res_q.bit_count, m_res_q.is_member};

  // The RAM is never written while words are being streamed out of it.
  `BVS_ASSERT_IMPL(a_no_write_during_walk, clk_i, rst_ni, ram_we, !walk_ctl.vld)
  // No word may still be in flight in the word unit once a new item can enter.
  `BVS_ASSERT_IMPL(a_idle_unit_quiet, clk_i, rst_ni, state_q == ST_IDLE, !walk_acc.busy)
  // A read-modify-write only touches a word inside the words in use.
  `BVS_ASSERT_IMPL(a_modify_in_range, clk_i, rst_ni, state_q == ST_MODIFY, nw > 5'(idx_q[9:6]))
  // A finished result waits rather than overwrite an untaken one.
  `BVS_ASSERT_NEXT(a_finish_waits, clk_i, rst_ni,
    state_q == ST_FINISH && m_valid_q && !m_axis_tready,
    state_q == ST_FINISH && m_valid_q)

endmodule

// ===== tb/bvs_stream_checker.sv =====
// Scoreboard for the bit vector store: keeps its own copy of the word store and the
// word count, predicts one result per accepted input transaction and compares outputs.
// Depends on bvs_pkg for widths, constants and the action and status codes.
`timescale 1ns / 1ps

module bvs_stream_checker #(
  parameter int unsigned WORDS = bvs_pkg::WordsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bvs_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [bvs_pkg::InTdataW-1:0]  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [bvs_pkg::OutTdataW-1:0] out_data_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);

  import bvs_pkg::*;

  logic [WordBits-1:0] shadow_words[WORDS];
  logic [CfgW-1:0]     shadow_word_count;
  result_t             awaited_results[$];

  function automatic result_t apply_request(logic [2:0] act, logic [IdxW-1:0] idx);
    result_t             res;
    int unsigned         active;
    int unsigned         word_sel;
    logic [WordBits-1:0] h;
    logic [WordBits-1:0] w;
    bit                  found;
    res = '0;
    res.status = STAT_OK;
    active = (shadow_word_count > WORDS) ? WORDS : shadow_word_count;
    word_sel = idx[9:6];
    found = 1'b0;
    case (act)
      ACT_SET, ACT_CLEAR, ACT_TEST: begin
        if (word_sel >= active) begin
          res.status = STAT_RANGE;
        end else if (act == ACT_SET) begin
          shadow_words[word_sel][idx[5:0]] = 1'b1;
        end else if (act == ACT_CLEAR) begin
          shadow_words[word_sel][idx[5:0]] = 1'b0;
        end else begin
          res.is_member = shadow_words[word_sel][idx[5:0]];
        end
      end
      ACT_CLEAR_ALL: begin
        for (int i = 0; i < WORDS; i++) shadow_words[i] = '0;
      end
      ACT_COUNT: begin
        for (int i = 0; i < active; i++) begin
          res.bit_count = res.bit_count + CountW'($countones(shadow_words[i]));
        end
      end
      ACT_LOWEST: begin
        res.status = STAT_EMPTY;
        for (int i = 0; i < active; i++) begin
          for (int b = 0; b < WordBits; b++) begin
            if (!found && shadow_words[i][b]) begin
              res.first_set = IdxW'(i * WordBits + b);
              res.status = STAT_OK;
              found = 1'b1;
            end
          end
        end
      end
      ACT_HASH: begin
        h = HashStart;
        for (int i = 0; i < active; i++) begin
          w = shadow_words[i];
          h = h ^ (w * 64'(i + 1));
          if (w != '0) h = h * HashMult;
        end
        res.hash_value = h[31:0] ^ h[63:32];
      end
      default: begin
        // An undefined action leaves the store alone and answers with zeros.
      end
    endcase
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < WORDS; i++) shadow_words[i] = '0;
      shadow_word_count = WordsInUseReset;
      awaited_results.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no request waiting: tdata %h", out_data_i);
          mismatch_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("is_member", 32'(want.is_member), 32'(out_data_i[0]));
          check_field("bit_count", 32'(want.bit_count), 32'(out_data_i[11:1]));
          check_field("first_set", 32'(want.first_set), 32'(out_data_i[21:12]));
          check_field("hash_value", want.hash_value, out_data_i[53:22]);
          check_field("status", 32'(want.status), 32'(out_data_i[55:54]));
        end
      end
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(apply_request(in_data_i[2:0], in_data_i[12:3]));
      end
      // Writes only come while the block is idle, so ordering against requests is moot.
      if (cfg_we_i) shadow_word_count = cfg_wdata_i;
      outstanding_o = awaited_results.size();
    end
  end

endmodule

// ===== tb/bit_vector_store_core_test.sv =====
// Top of the bit vector store testbench: clock, reset, register writes, request and
// result stream stimulus with random stalls, and the final verdict.
// Depends on bvs_pkg, bit_vector_store_core and bvs_stream_checker.
`timescale 1ns / 1ps

module bit_vector_store_core_test;

  import bvs_pkg::*;

  localparam int unsigned WORDS        = WordsDefault;
  localparam logic [2:0]  ActUnused    = 3'd7;
  localparam int unsigned SettleCycles = WORDS + 8;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 170;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CfgW-1:0]       cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InTdataW-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutTdataW-1:0]  m_axis_tdata;

  int                    mismatches;
  int                    outstanding;
  bit                    steady_flow;
  bit                    hold_request;
  int unsigned           word_count;

  bit_vector_store_core #(
    .WORDS(WORDS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  bvs_stream_checker #(
    .WORDS(WORDS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("simulation failed");
    $finish;
  end

  // Result side: random stall bursts, a long hold-off whenever one is requested, none at the end.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Entered and left at a falling edge; tvalid stays high after the transaction.
  task automatic send_request(input logic [2:0] act, input logic [IdxW-1:0] idx);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, idx, act};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_word_count(input int unsigned value);
    drain_results();
    cfg_wdata_i <= CfgW'(value);
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    word_count = value;
  endtask

  function automatic logic [12:0] random_request(int unsigned words);
    int unsigned roll;
    int unsigned span;
    logic [2:0]  act;
    logic [9:0]  idx;
    span = (words > WORDS) ? WORDS : words;
    roll = $urandom_range(0, 99);
    if (roll < 28)      act = ACT_SET;
    else if (roll < 48) act = ACT_CLEAR;
    else if (roll < 64) act = ACT_TEST;
    else if (roll < 72) act = ACT_COUNT;
    else if (roll < 80) act = ACT_LOWEST;
    else if (roll < 88) act = ACT_HASH;
    else if (roll < 91) act = ACT_CLEAR_ALL;
    else if (roll < 93) act = ActUnused;
    else                act = ACT_TEST;
    // Mostly indexes inside the words in use, with some anywhere in the field.
    if (span == 0 || roll >= 93 || $urandom_range(0, 9) == 0) begin
      idx = 10'($urandom);
    end else begin
      idx = 10'($urandom_range(0, span * WordBits - 1));
    end
    return {idx, act};
  endfunction

  initial begin
    int unsigned phase_words[11];
    logic [12:0] req;
    phase_words = '{16, 1, 4, 0, 31, 9, 16, 2, 17, 12, 16};
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    steady_flow   = 1'b0;
    hold_request  = 1'b0;
    word_count    = WordsInUseReset;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: empty store, edge indexes, every action, saturation and zero words.
    send_request(ACT_LOWEST, 10'd0);
    send_request(ACT_COUNT, 10'd0);
    send_request(ACT_HASH, 10'd0);
    send_request(ACT_SET, 10'd1023);
    send_request(ACT_LOWEST, 10'd0);
    send_request(ACT_SET, 10'd0);
    send_request(ACT_SET, 10'd63);
    send_request(ACT_SET, 10'd64);
    send_request(ACT_TEST, 10'd1023);
    send_request(ACT_TEST, 10'd5);
    send_request(ACT_COUNT, 10'd0);
    send_request(ACT_HASH, 10'd0);
    send_request(ACT_CLEAR, 10'd0);
    send_request(ACT_LOWEST, 10'd0);
    send_request(ActUnused, 10'd1023);
    send_request(ACT_CLEAR_ALL, 10'd0);
    send_request(ACT_TEST, 10'd63);
    send_request(ACT_COUNT, 10'd0);
    set_word_count(1);
    send_request(ACT_SET, 10'd64);
    send_request(ACT_CLEAR, 10'd1023);
    send_request(ACT_SET, 10'd63);
    send_request(ACT_HASH, 10'd0);
    set_word_count(0);
    send_request(ACT_TEST, 10'd0);
    send_request(ACT_LOWEST, 10'd0);
    send_request(ACT_HASH, 10'd0);
    set_word_count(31);
    send_request(ACT_SET, 10'd1023);
    send_request(ACT_COUNT, 10'd0);

    // Random part, one register setting per phase.
    for (int p = 0; p < 11; p++) begin
      set_word_count(phase_words[p]);
      if (p == 10) steady_flow = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        if ((p == 1 || p == 6) && n == PhaseItems / 2) hold_request = 1'b1;
        if (p == 3 && n == PhaseItems / 2) begin
          s_axis_tvalid <= 1'b0;
          while (outstanding != 0) @(negedge clk_i);
        end
        req = random_request(word_count);
        send_request(req[2:0], req[12:3]);
      end
    end

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
